// ----- rtl/akvfd_pkg.sv -----
`default_nettype none

package akvfd_pkg;

    localparam logic [7:0] CH_START = 8'h40;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam int BODY_NUM_START = 3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_start;
        logic       is_bar;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic       is_space;
        logic       is_minus;
        logic       is_plus;
    } t_cls;

    typedef struct packed {
        logic [7:0]         key;
        logic signed [31:0] value;
        logic               ok;
    } t_res;

    typedef enum logic [3:0] {
        FR_HUNT = 4'b0001,
        FR_BODY = 4'b0010,
        FR_BAR  = 4'b0100,
        FR_CR   = 4'b1000
    } t_frame_ph;

    typedef enum logic [3:0] {
        NUM_WS     = 4'b0001,
        NUM_SIGN   = 4'b0010,
        NUM_DIGITS = 4'b0100,
        NUM_DONE   = 4'b1000
    } t_num_ph;

endpackage

`default_nettype wire

// ----- rtl/akvfd_fifo.sv -----
`default_nettype none

module akvfd_fifo #(
    parameter type T = logic [7:0]
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  T     i_data,
    output logic o_full,
    input  wire  i_pop,
    output logic o_empty,
    output T     o_data
);
    import akvfd_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    T                r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/akvfd_front.sv -----
`default_nettype none

module akvfd_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [7:0]       i_rx_byte,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output akvfd_pkg::t_cls  o_cls
);
    import akvfd_pkg::*;

    t_cls cls;
    logic empty;

    always_comb begin
        cls.ch       = i_rx_byte;
        cls.is_start = (i_rx_byte == CH_START);
        cls.is_bar   = (i_rx_byte == CH_BAR);
        cls.is_cr    = (i_rx_byte == CH_CR);
        cls.is_lf    = (i_rx_byte == CH_LF);
        cls.is_digit = (i_rx_byte inside {[CH_ZERO:CH_NINE]});
        cls.is_space = (i_rx_byte inside {CH_SPACE, [CH_TAB:CH_CR]});
        cls.is_minus = (i_rx_byte == CH_MINUS);
        cls.is_plus  = (i_rx_byte == CH_PLUS);
    end

    akvfd_fifo #(.T(t_cls)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (empty),
        .o_data  (o_cls)
    );

    assign o_valid = ~empty;

endmodule

`default_nettype wire

// ----- rtl/akvfd_back.sv -----
`default_nettype none

module akvfd_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  akvfd_pkg::t_cls  i_cls,
    output logic             o_pop,
    input  wire              i_pop,
    output logic             o_empty,
    output akvfd_pkg::t_res  o_res
);
    import akvfd_pkg::*;

    t_frame_ph    r_frame, n_frame;
    t_num_ph      r_num, n_num;
    logic [1:0]   r_pos, n_pos;
    logic [7:0]   r_key, n_key;
    logic         r_neg, n_neg;
    logic         r_seen, n_seen;
    logic [31:0]  r_acc, n_acc;

    logic         res_full;
    logic         go;
    logic         emit;
    t_res         res;
    logic [31:0]  acc_next;
    logic [31:0]  mag;

    assign go       = i_valid & ~res_full;
    assign o_pop    = go;
    assign acc_next = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, i_cls.ch[3:0]};
    assign mag      = r_neg ? (32'd0 - r_acc) : r_acc;

    always_comb begin
        res.key   = r_key;
        res.value = r_seen ? $signed(mag) : 32'sd0;
        res.ok    = r_seen;
    end

    always_comb begin
        n_frame = r_frame;
        n_num   = r_num;
        n_pos   = r_pos;
        n_key   = r_key;
        n_neg   = r_neg;
        n_seen  = r_seen;
        n_acc   = r_acc;
        emit    = 1'b0;
        if (go) begin
            if (i_cls.is_start) begin
                n_frame = FR_BODY;
                n_num   = NUM_WS;
                n_pos   = 2'd0;
                n_key   = 8'd0;
                n_neg   = 1'b0;
                n_seen  = 1'b0;
                n_acc   = 32'd0;
            end else begin
                case (r_frame)
                    FR_HUNT: begin
                    end
                    FR_BODY: begin
                        if (i_cls.is_bar) begin
                            n_frame = FR_BAR;
                        end else if (r_pos == 2'd0) begin
                            n_key = i_cls.ch;
                            n_pos = 2'd1;
                        end else if (r_pos == 2'd1) begin
                            n_pos = 2'(BODY_NUM_START - 1);
                        end else if (r_num != NUM_DONE) begin
                            if (i_cls.is_digit) begin
                                n_acc  = acc_next;
                                n_seen = 1'b1;
                                n_num  = NUM_DIGITS;
                            end else if (r_num == NUM_WS && i_cls.is_space) begin
                            end else if (r_num == NUM_WS && (i_cls.is_minus || i_cls.is_plus)) begin
                                n_neg = i_cls.is_minus;
                                n_num = NUM_SIGN;
                            end else begin
                                n_num = NUM_DONE;
                            end
                        end
                    end
                    FR_BAR: begin
                        if (i_cls.is_cr) begin
                            n_frame = FR_CR;
                        end else begin
                            n_frame = FR_HUNT;
                            n_num   = NUM_WS;
                            n_pos   = 2'd0;
                            n_key   = 8'd0;
                            n_neg   = 1'b0;
                            n_seen  = 1'b0;
                            n_acc   = 32'd0;
                        end
                    end
                    FR_CR: begin
                        emit    = i_cls.is_lf;
                        n_frame = FR_HUNT;
                        n_num   = NUM_WS;
                        n_pos   = 2'd0;
                        n_key   = 8'd0;
                        n_neg   = 1'b0;
                        n_seen  = 1'b0;
                        n_acc   = 32'd0;
                    end
                    default: begin
                        n_frame = FR_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= FR_HUNT;
            r_num   <= NUM_WS;
            r_pos   <= 2'd0;
            r_key   <= 8'd0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_acc   <= 32'd0;
        end else begin
            r_frame <= n_frame;
            r_num   <= n_num;
            r_pos   <= n_pos;
            r_key   <= n_key;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_acc   <= n_acc;
        end
    end

    akvfd_fifo #(.T(t_res)) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_res)
    );

endmodule

`default_nettype wire

// ----- rtl/ascii_key_value_frame_decoder.sv -----
// ASCII key/value frame decoder.
// Input channel: a byte on i_rx_byte transfers on a rising edge with push high
// and full low. Frames are '@', key, one ignored byte, an optional signed
// decimal number, '|', CR, LF. A '@' restarts the frame at any point.
// Result channel: while empty is low, o_msg_key, o_msg_value and o_decode_ok
// hold the oldest result; it transfers on an edge with pop high and empty low.
// One result is made per LF that closes a valid frame; o_decode_ok is 1 when
// at least one digit was parsed, else o_msg_value is 0. The value wraps mod 2^32.
// Throughput: one byte per cycle while the result queue has room. Bytes go
// through a two-entry classify queue; the parse stage consumes one byte per
// cycle (one times-ten accumulate) unless the result queue is full, and
// results go through a two-entry result queue. A result is written into
// the result queue when the parse stage pops its LF from the classify queue.
// Stalls: if pop stays low the result queue fills, the parse stage stops, then
// the input queue fills and full rises; nothing is lost.
// Reset (i_rst_n low at an edge) empties both queues and returns to hunting.
`default_nettype none

module ascii_key_value_frame_decoder (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                push,
    input  wire  [7:0]         i_rx_byte,
    output logic               full,
    input  wire                pop,
    output logic               empty,
    output logic [7:0]         o_msg_key,
    output logic signed [31:0] o_msg_value,
    output logic               o_decode_ok
);
    import akvfd_pkg::*;

    logic cls_valid;
    logic cls_pop;
    t_cls cls;
    t_res res;

    akvfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rx_byte (i_rx_byte),
        .o_full    (full),
        .i_pop     (cls_pop),
        .o_valid   (cls_valid),
        .o_cls     (cls)
    );

    akvfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .i_cls   (cls),
        .o_pop   (cls_pop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res)
    );

    assign o_msg_key   = res.key;
    assign o_msg_value = res.value;
    assign o_decode_ok = res.ok;

endmodule

`default_nettype wire
